// ----- design/sda_pkg.sv -----
// Shared types and constants for the stillness detector and accumulator.
package sda_pkg;

  localparam int AXES           = 3;
  localparam int NUM_AXIS_PORTS = 3;
  localparam int SAMPLE_BITS    = 24;
  localparam int SUM_BITS       = 40;
  localparam int COUNT_BITS     = 15;
  localparam int TOL_BITS       = 16;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DIFF_BITS      = (SAMPLE_BITS + 2 > TOL_BITS + 1) ? SAMPLE_BITS + 2
                                                                    : TOL_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT        = COUNT_BITS'(32000);
  localparam logic [COUNT_BITS-1:0] COUNT_NEEDED_RESET = COUNT_BITS'(8);

  typedef enum logic [1:0] {
    STAGE_NOT_STILL = 2'd0,
    STAGE_SETTLING  = 2'd1,
    STAGE_STILL     = 2'd2
  } stage_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TOLERANCE    = 1'b0,
    CFG_COUNT_NEEDED = 1'b1
  } cfg_idx_t;

  // Per-axis update control, built in the top level from the update strobe and the stage logic.
  typedef struct packed {
    logic upd;
    logic moved;
    logic acc;
    logic halve;
  } axis_ctl_t;

  // Stage logic results for the current item.
  typedef struct packed {
    stage_t                stage;
    logic [COUNT_BITS-1:0] count;
    logic                  acc;
    logic                  halve;
  } stage_info_t;

endpackage

// ----- design/sda_axis.sv -----
// One axis: min/max tracking, tolerance check and running sum.
module sda_axis (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sda_pkg::axis_ctl_t                   ctl,
  input  logic signed [sda_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [sda_pkg::TOL_BITS-1:0]         tolerance,
  output logic                                 exceed,
  output logic signed [sda_pkg::SUM_BITS-1:0]  sum_nxt
);

  logic signed [sda_pkg::SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [sda_pkg::SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [sda_pkg::SUM_BITS-1:0]    sum_r, sum_acc;
  logic signed [sda_pkg::DIFF_BITS-1:0]   d_ext, min_ext, max_ext, tol_ext;
  logic signed [sda_pkg::DIFF_BITS-1:0]   spread_lo, spread_hi;
  logic                                   lo_new, hi_new;

  always_comb begin
    d_ext     = sda_pkg::DIFF_BITS'(sample);
    min_ext   = sda_pkg::DIFF_BITS'(min_r);
    max_ext   = sda_pkg::DIFF_BITS'(max_r);
    tol_ext   = sda_pkg::DIFF_BITS'(tolerance);
    lo_new    = min_r > sample;
    hi_new    = max_r < sample;
    spread_lo = max_ext - d_ext;
    spread_hi = d_ext - min_ext;
    exceed    = (lo_new && (spread_lo > tol_ext)) ||
                (!lo_new && hi_new && (spread_hi > tol_ext));
  end

  always_comb begin
    sum_acc = ctl.acc ? sum_r + sda_pkg::SUM_BITS'(sample) : sum_r;
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    if (ctl.upd) begin
      if (ctl.moved) begin
        // restart the window at this sample
        min_nxt = sample;
        max_nxt = sample;
        sum_nxt = '0;
      end else begin
        if (lo_new) min_nxt = sample;
        if (hi_new) max_nxt = sample;
        sum_nxt = ctl.halve ? (sum_acc >>> 1) : sum_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= '0;
      sum_r <= '0;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- design/sda_stage.sv -----
// Stage sequencing and sample count.
module sda_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             upd,
  input  logic                             moved,
  input  logic [sda_pkg::COUNT_BITS-1:0]   count_needed,
  output sda_pkg::stage_info_t             info
);

  sda_pkg::stage_t                 stage_r, stage_nxt, stage_adv;
  logic [sda_pkg::COUNT_BITS-1:0]  count_r, count_nxt, count_adv, count_inc, count_fin;
  logic                            halve;

  always_comb begin
    stage_adv = stage_r;
    count_adv = count_r;
    if (stage_r != sda_pkg::STAGE_STILL && count_r >= count_needed) begin
      unique case (stage_r)
        sda_pkg::STAGE_NOT_STILL: begin
          stage_adv = sda_pkg::STAGE_SETTLING;
          count_adv = '0;
        end
        sda_pkg::STAGE_SETTLING: stage_adv = sda_pkg::STAGE_STILL;
        default:                 stage_adv = stage_r;
      endcase
    end
    count_inc = count_adv + sda_pkg::COUNT_BITS'(1);
    halve     = count_inc > sda_pkg::COUNT_LIMIT;
    count_fin = halve ? (count_inc >> 1) : count_inc;

    stage_nxt = stage_r;
    count_nxt = count_r;
    if (upd) begin
      if (moved) begin
        stage_nxt = sda_pkg::STAGE_NOT_STILL;
        count_nxt = '0;
      end else begin
        stage_nxt = stage_adv;
        count_nxt = count_fin;
      end
    end

    info.stage = stage_nxt;
    info.count = count_nxt;
    info.acc   = stage_adv != sda_pkg::STAGE_NOT_STILL;
    info.halve = halve;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= sda_pkg::STAGE_NOT_STILL;
      count_r <= '0;
    end else begin
      stage_r <= stage_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/stillness_detector_accumulator_top.sv -----
// Stillness detector and accumulator top level: input register, update logic, result register.
// The input transaction loads the input register; the result register loads on advance and raises out_valid.
// Throughput: 1 sample per cycle while results are taken; the per-axis compare/add and stage update are combinational.
// The input register can take one sample while a finished result waits for out_ready, then stalls.
// Reset (rst_n low, synchronous): both registers empty, stage not still, count, min, max and
// sums zero, tolerance 0, count_needed 8.
module stillness_detector_accumulator_top (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [sda_pkg::CFG_IDX_BITS-1:0]          cfg_index,
  input  logic [sda_pkg::CFG_DATA_BITS-1:0]         cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [sda_pkg::SAMPLE_BITS-1:0]    in_sample_x,
  input  logic signed [sda_pkg::SAMPLE_BITS-1:0]    in_sample_y,
  input  logic signed [sda_pkg::SAMPLE_BITS-1:0]    in_sample_z,
  input  logic                                      in_saturated,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [1:0]                                out_still_stage,
  output logic                                      out_moved,
  output logic [sda_pkg::COUNT_BITS-1:0]            out_sample_count,
  output logic signed [sda_pkg::SUM_BITS-1:0]       out_sum_x,
  output logic signed [sda_pkg::SUM_BITS-1:0]       out_sum_y,
  output logic signed [sda_pkg::SUM_BITS-1:0]       out_sum_z
);

  logic [sda_pkg::TOL_BITS-1:0]   tolerance_r;
  logic [sda_pkg::COUNT_BITS-1:0] count_needed_r;

  logic                                   ir_valid_r;
  logic signed [sda_pkg::SAMPLE_BITS-1:0] samp_r [sda_pkg::NUM_AXIS_PORTS];
  logic                                   sat_r;
  logic                                   advance, upd, moved;

  logic [sda_pkg::NUM_AXIS_PORTS-1:0]     exceed;
  logic signed [sda_pkg::SUM_BITS-1:0]    sum_nxt [sda_pkg::NUM_AXIS_PORTS];
  sda_pkg::axis_ctl_t                     axis_ctl;
  sda_pkg::stage_info_t                   info;

  logic                                   out_valid_r;
  logic [1:0]                             still_stage_r;
  logic                                   moved_r;
  logic [sda_pkg::COUNT_BITS-1:0]         count_r;
  logic signed [sda_pkg::SUM_BITS-1:0]    sum_r [sda_pkg::NUM_AXIS_PORTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r    <= '0;
      count_needed_r <= sda_pkg::COUNT_NEEDED_RESET;
    end else if (cfg_valid) begin
      unique case (sda_pkg::cfg_idx_t'(cfg_index))
        sda_pkg::CFG_TOLERANCE:    tolerance_r    <= cfg_data[sda_pkg::TOL_BITS-1:0];
        sda_pkg::CFG_COUNT_NEEDED: count_needed_r <= cfg_data[sda_pkg::COUNT_BITS-1:0];
      endcase
    end
  end

  assign advance  = ir_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ir_valid_r || advance;
  assign upd      = advance && !sat_r;
  assign moved    = !sat_r && (|exceed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_ready) begin
      ir_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      samp_r[0] <= in_sample_x;
      samp_r[1] <= in_sample_y;
      samp_r[2] <= in_sample_z;
      sat_r     <= in_saturated;
    end
  end

  always_comb begin
    axis_ctl.upd   = upd;
    axis_ctl.moved = moved;
    axis_ctl.acc   = info.acc;
    axis_ctl.halve = info.halve;
  end

  for (genvar i = 0; i < sda_pkg::NUM_AXIS_PORTS; i++) begin : g_axis
    if (i < sda_pkg::AXES) begin : g_used
      sda_axis u_axis (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (axis_ctl),
        .sample    (samp_r[i]),
        .tolerance (tolerance_r),
        .exceed    (exceed[i]),
        .sum_nxt   (sum_nxt[i])
      );
    end else begin : g_unused
      assign exceed[i]  = 1'b0;
      assign sum_nxt[i] = '0;
    end
  end

  sda_stage u_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (upd),
    .moved        (moved),
    .count_needed (count_needed_r),
    .info         (info)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result until taken; latch a new one on each advance
  always_ff @(posedge clk) begin
    if (advance) begin
      still_stage_r <= info.stage;
      moved_r       <= moved;
      count_r       <= info.count;
      sum_r[0]      <= sum_nxt[0];
      sum_r[1]      <= sum_nxt[1];
      sum_r[2]      <= sum_nxt[2];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_still_stage  = still_stage_r;
  assign out_moved        = moved_r;
  assign out_sample_count = count_r;
  assign out_sum_x        = sum_r[0];
  assign out_sum_y        = sum_r[1];
  assign out_sum_z        = sum_r[2];

endmodule

// ----- tb/stillness_detector_accumulator_checker.sv -----
// Checker for the stillness detector: tracks config and samples, predicts results, compares.
`timescale 1ns / 1ps

module stillness_detector_accumulator_checker
  import sda_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_z,
  input  logic                          in_saturated,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    out_still_stage,
  input  logic                          out_moved,
  input  logic [COUNT_BITS-1:0]         out_sample_count,
  input  logic signed [SUM_BITS-1:0]    out_sum_x,
  input  logic signed [SUM_BITS-1:0]    out_sum_y,
  input  logic signed [SUM_BITS-1:0]    out_sum_z,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct packed {
    stage_t                stage;
    logic                  moved;
    logic [COUNT_BITS-1:0] count;
    logic [SUM_BITS-1:0]   sum_x;
    logic [SUM_BITS-1:0]   sum_y;
    logic [SUM_BITS-1:0]   sum_z;
  } stillness_result_t;

  logic [TOL_BITS-1:0]   tolerance_q;
  logic [COUNT_BITS-1:0] needed_q;
  longint                win_lo[AXES];
  longint                win_hi[AXES];
  logic [SUM_BITS-1:0]   axis_acc[NUM_AXIS_PORTS];
  stage_t                cur_stage;
  logic [COUNT_BITS-1:0] cur_count;
  stillness_result_t     expected_results[$];
  int                    errors = 0;

  assign mismatches = errors;

  task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  task clear_detector();
    tolerance_q = '0;
    needed_q    = COUNT_NEEDED_RESET;
    for (int i = 0; i < AXES; i++) begin
      win_lo[i] = 0;
      win_hi[i] = 0;
    end
    for (int i = 0; i < NUM_AXIS_PORTS; i++) axis_acc[i] = '0;
    cur_stage = STAGE_NOT_STILL;
    cur_count = '0;
  endtask

  // Advance the detector by one sample and queue the result it produces.
  task track_sample(input longint sx, input longint sy, input longint sz, input logic sat);
    longint            smp[NUM_AXIS_PORTS];
    logic              motion;
    stillness_result_t r;
    smp[0] = sx;
    smp[1] = sy;
    smp[2] = sz;
    motion = 1'b0;
    if (!sat) begin
      for (int i = 0; i < AXES; i++) begin
        if (win_lo[i] > smp[i]) begin
          if (win_hi[i] - smp[i] > longint'(tolerance_q)) motion = 1'b1;
          else win_lo[i] = smp[i];
        end else if (win_hi[i] < smp[i]) begin
          if (smp[i] - win_lo[i] > longint'(tolerance_q)) motion = 1'b1;
          else win_hi[i] = smp[i];
        end
      end
      if (motion) begin
        cur_stage = STAGE_NOT_STILL;
        cur_count = '0;
        for (int i = 0; i < AXES; i++) begin
          win_lo[i]   = smp[i];
          win_hi[i]   = smp[i];
          axis_acc[i] = '0;
        end
      end else begin
        if (cur_stage != STAGE_STILL && cur_count >= needed_q) begin
          // count restarts only when leaving not-still
          if (cur_stage == STAGE_NOT_STILL) begin
            cur_count = '0;
            cur_stage = STAGE_SETTLING;
          end else begin
            cur_stage = STAGE_STILL;
          end
        end
        if (cur_stage != STAGE_NOT_STILL)
          for (int i = 0; i < AXES; i++) axis_acc[i] = axis_acc[i] + smp[i][SUM_BITS-1:0];
        cur_count = cur_count + 1'b1;
        if (cur_count > COUNT_LIMIT) begin
          for (int i = 0; i < AXES; i++) axis_acc[i] = $signed(axis_acc[i]) >>> 1;
          cur_count = cur_count >> 1;
        end
      end
    end
    r.stage = cur_stage;
    r.moved = motion;
    r.count = cur_count;
    r.sum_x = axis_acc[0];
    r.sum_y = axis_acc[1];
    r.sum_z = axis_acc[2];
    expected_results.push_back(r);
  endtask

  task check_result();
    stillness_result_t want;
    want = expected_results.pop_front();
    if (out_still_stage !== want.stage) report_mismatch("still_stage", out_still_stage, want.stage);
    if (out_moved !== want.moved) report_mismatch("moved", out_moved, want.moved);
    if (out_sample_count !== want.count)
      report_mismatch("sample_count", out_sample_count, want.count);
    if (out_sum_x !== want.sum_x) report_mismatch("sum_x", {out_sum_x}, want.sum_x);
    if (out_sum_y !== want.sum_y) report_mismatch("sum_y", {out_sum_y}, want.sum_y);
    if (out_sum_z !== want.sum_z) report_mismatch("sum_z", {out_sum_z}, want.sum_z);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_detector();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) report_mismatch("result with no sample pending", 1, 0);
        else check_result();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TOLERANCE:    tolerance_q = cfg_data[TOL_BITS-1:0];
          CFG_COUNT_NEEDED: needed_q    = cfg_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) track_sample(in_sample_x, in_sample_y, in_sample_z, in_saturated);
    end
    outstanding <= expected_results.size();
  end

endmodule

// ----- tb/stillness_detector_accumulator_top_tb.sv -----
// Testbench top for the stillness detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module stillness_detector_accumulator_top_tb;
  import sda_pkg::*;

  localparam int     CYCLE_LIMIT    = 5_000_000;
  localparam int     PHASE_ITEMS    = 150;
  localparam int     STALL_CYCLES   = 120;
  localparam int     DRAIN_CYCLES   = 4;
  localparam longint SAMPLE_MIN     = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam longint SAMPLE_MAX     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

  logic                          clk              = 1'b0;
  logic                          rst_n            = 1'b0;
  logic                          cfg_valid        = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_BITS-1:0]       cfg_index        = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data         = '0;
  logic                          in_valid         = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample_x      = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_y      = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_z      = '0;
  logic                          in_saturated     = 1'b0;
  logic                          out_valid;
  logic                          out_ready        = 1'b0;
  logic [1:0]                    out_still_stage;
  logic                          out_moved;
  logic [COUNT_BITS-1:0]         out_sample_count;
  logic signed [SUM_BITS-1:0]    out_sum_x;
  logic signed [SUM_BITS-1:0]    out_sum_y;
  logic signed [SUM_BITS-1:0]    out_sum_z;

  int                  failures;
  int                  outstanding;
  int                  idle_pct     = 0;
  int                  stall_ticket = 0;
  int                  cycles       = 0;
  int                  sent         = 0;
  int                  need_now     = 8;
  logic [TOL_BITS-1:0] tol_now      = '0;

  stillness_detector_accumulator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .in_sample_z      (in_sample_z),
    .in_saturated     (in_saturated),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_still_stage  (out_still_stage),
    .out_moved        (out_moved),
    .out_sample_count (out_sample_count),
    .out_sum_x        (out_sum_x),
    .out_sum_y        (out_sum_y),
    .out_sum_z        (out_sum_z)
  );

  stillness_detector_accumulator_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .in_sample_z      (in_sample_z),
    .in_saturated     (in_saturated),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_still_stage  (out_still_stage),
    .out_moved        (out_moved),
    .out_sample_count (out_sample_count),
    .out_sum_x        (out_sum_x),
    .out_sum_y        (out_sum_y),
    .out_sum_z        (out_sum_z),
    .mismatches       (failures),
    .outstanding      (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stillness_detector_accumulator_top_tb: FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure bursts plus a long hold-off on request.
  initial begin
    int stall_seen;
    stall_seen = 0;
    forever begin
      @(posedge clk);
      if (stall_ticket != stall_seen) begin
        stall_seen = stall_ticket;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] fit_sample(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX[SAMPLE_BITS-1:0];
    if (v < SAMPLE_MIN) return SAMPLE_MIN[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic longint any_sample();
    logic signed [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom());
    return v;
  endfunction

  // Low end of a window of width tol_now that leaves room for one step past it.
  function automatic longint window_base();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return SAMPLE_MIN;
    if (pick == 1) return SAMPLE_MAX - longint'(tol_now) - 1;
    return SAMPLE_MIN + longint'($urandom_range(0, (1 << SAMPLE_BITS) - 2 - tol_now));
  endfunction

  task send_sample(input longint x, input longint y, input longint z, input logic sat);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_x  <= fit_sample(x);
    in_sample_y  <= fit_sample(y);
    in_sample_z  <= fit_sample(z);
    in_saturated <= sat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task set_config(input logic [CFG_DATA_BITS-1:0] tol, input logic [CFG_DATA_BITS-1:0] need);
    wait_drained();
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_COUNT_NEEDED, need);
    cfg_valid <= 1'b0;
    tol_now  = tol[TOL_BITS-1:0];
    need_now = int'(need[COUNT_BITS-1:0]);
  endtask

  // Quiet run inside one tolerance window, optionally ended by a step just past it.
  task window_run(input int len, input bit break_it);
    longint bx;
    longint by;
    longint bz;
    int     ax;
    bx = window_base();
    by = window_base();
    bz = window_base();
    send_sample(bx, by, bz, 1'b0);
    for (int k = 1; k < len; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_sample(any_sample(), any_sample(), any_sample(), 1'b1);
      else if ($urandom_range(0, 9) == 0)
        send_sample(bx + tol_now, by + tol_now, bz + tol_now, 1'b0);
      else
        send_sample(bx + $urandom_range(0, tol_now), by + $urandom_range(0, tol_now),
                    bz + $urandom_range(0, tol_now), 1'b0);
    end
    if (break_it) begin
      ax = $urandom_range(0, 2);
      send_sample(bx + tol_now + (ax == 0), by + tol_now + (ax == 1),
                  bz + tol_now + (ax == 2), 1'b0);
    end
  endtask

  task run_phase(input int n, input int pct, input bit with_stall, input bit with_pause);
    int goal;
    int kind;
    int len;
    idle_pct = pct;
    goal     = sent + n;
    if (with_stall) stall_ticket <= stall_ticket + 1;
    while (sent < goal) begin
      if (with_pause && sent >= goal - n / 2) begin
        wait_drained();
        with_pause = 1'b0;
      end
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, (need_now < 25) ? 3 * need_now + 6 : 40);
      if (kind < 65) window_run(len, 1'b0);
      else if (kind < 85) window_run(len, 1'b1);
      else send_sample(any_sample(), any_sample(), any_sample(), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero tolerance, count needed 8
    repeat (10) send_sample(0, 0, 0, 1'b0);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, 1, 1'b0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, -1, 1'b0);

    // widest tolerance, count needed zero: advance on every quiet sample
    set_config(16'hFFFF, 16'h0000);
    send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN + 65535, SAMPLE_MIN + 65535, SAMPLE_MIN + 65535, 1'b0);
    send_sample(SAMPLE_MIN + 65536, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN + 65536, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN + 65536, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample(0, 0, 0, 1'b1);
    send_sample(SAMPLE_MAX, 0, -1, 1'b0);

    set_config(16'h0000, 16'h0001);
    run_phase(PHASE_ITEMS, 10, 1'b0, 1'b0);
    // count needed beyond the limit: never leaves not-still
    set_config(16'hFFFF, 16'hFFFF);
    run_phase(PHASE_ITEMS, 25, 1'b1, 1'b0);
    set_config(16'd1000, 16'd3);
    run_phase(PHASE_ITEMS, 0, 1'b0, 1'b0);
    set_config(CFG_DATA_BITS'($urandom_range(0, 65535)), CFG_DATA_BITS'($urandom_range(1, 20)));
    run_phase(PHASE_ITEMS, 15, 1'b0, 1'b1);
    set_config(16'd300, 16'd5);
    run_phase(PHASE_ITEMS, 10, 1'b1, 1'b0);
    set_config(16'd5000, 16'd4);
    run_phase(PHASE_ITEMS, 0, 1'b0, 1'b0);

    wait_drained();
    if (failures == 0) begin
      $display("stillness_detector_accumulator_top_tb: PASS");
    end else begin
      $display("stillness_detector_accumulator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
